### rtl/core/assert_macros.svh
// assertion macros used by the rtl file pbp_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define PBP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

// condition that must never be true out of reset
`define PBP_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

### rtl/core/pbp_pkg.sv
// ----------------------------------------------------------------------------
// pbp_pkg
// sizes, types and constants of the perceptron branch predictor
// ----------------------------------------------------------------------------
package pbp_pkg;

    localparam int ROW_COUNT   = 256;
    localparam int HIST_LEN    = 28;
    localparam int WEIGHT_BITS = 8;

    localparam int ROW_LEN  = HIST_LEN + 1;
    localparam int ROW_W    = ROW_LEN * WEIGHT_BITS;
    localparam int ROW_BITS = $clog2(ROW_COUNT);
    localparam int OUT_W    = 13;
    localparam int RAW_SUM_W = WEIGHT_BITS + $clog2(ROW_LEN) + 1;
    localparam int SUM_W    = (RAW_SUM_W > OUT_W) ? RAW_SUM_W : OUT_W;
    localparam int GRP      = 8;
    localparam int NGRP     = (ROW_LEN + GRP - 1) / GRP;

    localparam int THR_W     = 12;
    localparam int THR_RESET = 50;

    localparam int CMD_PREDICT = 0;
    localparam int CMD_TRAIN   = 1;

    // one request as it travels from the front queue to the back end
    typedef struct packed {
        logic                train;
        logic [ROW_BITS-1:0] row;
        logic                taken;
    } t_item;

endpackage

### rtl/core/pbp_front.sv
// ----------------------------------------------------------------------------
// pbp_front
// accepts requests, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module pbp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_command,
    input  logic [31:0]         i_pc,
    input  logic                i_outcome_taken,
    output logic                o_q_valid,
    output pbp_pkg::t_item      o_q_item,
    input  logic                i_q_pop
);

    pbp_pkg::t_item r_ent [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    pbp_pkg::t_item item;

    // classify the request
    always_comb begin
        item.train = (i_command == 1'(pbp_pkg::CMD_TRAIN));
        item.row   = i_pc[pbp_pkg::ROW_BITS-1:0];
        item.taken = i_outcome_taken;
    end

    assign busy      = (r_cnt == 2'd2);
    assign push      = start && !busy;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_ent[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wp] <= item;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

endmodule

### rtl/core/pbp_back.sv
// ----------------------------------------------------------------------------
// pbp_back
// reads the weight row, forms the sum, trains the row and the history
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbp_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  pbp_pkg::t_item                 i_q_item,
    output logic                           o_q_pop,
    input  logic                           i_thr_we,
    input  logic [pbp_pkg::THR_W-1:0]      i_thr_data,
    output logic                           o_valid,
    output logic                           o_predicted_taken,
    output logic signed [pbp_pkg::OUT_W-1:0] o_weighted_sum,
    output logic                           o_weights_adjusted
);

    localparam int W  = pbp_pkg::WEIGHT_BITS;
    localparam int SW = pbp_pkg::SUM_W;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PART = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;
    localparam logic signed [W-1:0] W_MAX = W'((1 << (W - 1)) - 1);
    localparam logic signed [W-1:0] W_MIN = W'(1 << (W - 1));
    localparam logic signed [SW-1:0] O_MAX = SW'((1 << (pbp_pkg::OUT_W - 1)) - 1);
    localparam logic signed [SW-1:0] O_MIN = -SW'(1 << (pbp_pkg::OUT_W - 1));

    logic [pbp_pkg::ROW_W-1:0]          r_mem [pbp_pkg::ROW_COUNT];
    logic [pbp_pkg::ROW_COUNT-1:0]      r_row_vld;
    logic [1:0]                         r_state, n_state;
    pbp_pkg::t_item                     r_item;
    logic [pbp_pkg::ROW_W-1:0]          r_rd;
    logic                               r_rd_vld;
    logic signed [SW-1:0]               r_part [pbp_pkg::NGRP];
    logic [pbp_pkg::HIST_LEN-1:0]       r_hist;
    logic [pbp_pkg::THR_W-1:0]          r_thr;
    logic                               r_valid, r_pred, r_adj;
    logic signed [pbp_pkg::OUT_W-1:0]   r_sum_out;

    logic signed [SW-1:0]               term [pbp_pkg::ROW_LEN];
    logic signed [SW-1:0]               n_part [pbp_pkg::NGRP];
    logic signed [SW-1:0]               sum, shown;
    logic [SW-1:0]                      mag;
    logic                               pred, adjust;
    logic [pbp_pkg::ROW_W-1:0]          new_row;

    // signed terms of the dot product, bias first
    always_comb begin
        logic signed [W-1:0] w;
        for (int k = 0; k < pbp_pkg::ROW_LEN; k++) begin
            w = r_rd_vld ? $signed(r_rd[k*W +: W]) : W'(0);
            if (k == 0 || r_hist[(k == 0) ? 0 : k - 1]) begin
                term[k] = SW'(w);
            end else begin
                term[k] = -SW'(w);
            end
        end
    end

    // first tree level: groups of up to eight terms
    always_comb begin
        for (int g = 0; g < pbp_pkg::NGRP; g++) begin
            n_part[g] = '0;
            for (int j = 0; j < pbp_pkg::GRP; j++) begin
                if (g * pbp_pkg::GRP + j < pbp_pkg::ROW_LEN) begin
                    n_part[g] = n_part[g] + term[g * pbp_pkg::GRP + j];
                end
            end
        end
    end

    // final sum, training decision and updated row
    always_comb begin
        logic signed [W-1:0] w;
        logic                up;
        sum = '0;
        for (int g = 0; g < pbp_pkg::NGRP; g++) begin
            sum = sum + r_part[g];
        end
        pred   = (sum >= 0);
        mag    = sum[SW-1] ? SW'(-sum) : SW'(sum);
        adjust = r_item.train &&
                 ((pred != r_item.taken) || (mag < SW'(r_thr)));
        for (int k = 0; k < pbp_pkg::ROW_LEN; k++) begin
            w  = r_rd_vld ? $signed(r_rd[k*W +: W]) : W'(0);
            up = (k == 0) ? r_item.taken
                          : (r_hist[(k == 0) ? 0 : k - 1] == r_item.taken);
            if (up && w != W_MAX) begin
                new_row[k*W +: W] = w + W'(1);
            end else if (!up && w != W_MIN) begin
                new_row[k*W +: W] = w - W'(1);
            end else begin
                new_row[k*W +: W] = w;
            end
        end
        if (sum > O_MAX) begin
            shown = O_MAX;
        end else if (sum < O_MIN) begin
            shown = O_MIN;
        end else begin
            shown = sum;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = S_PART;
                end
            end
            S_PART:  n_state = S_FIN;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // weight memory: registered read, write back when training adjusts the row
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rd <= r_mem[i_q_item.row];
        end
        if (r_state == S_FIN && adjust) begin
            r_mem[r_item.row] <= new_row;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
        end
        if (r_state == S_PART) begin
            r_part <= n_part;
        end
        r_sum_out <= shown[pbp_pkg::OUT_W-1:0];
        r_pred    <= pred;
        r_adj     <= adjust;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
            r_hist    <= '0;
            r_thr     <= pbp_pkg::THR_W'(pbp_pkg::THR_RESET);
            r_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_FIN);
            if (i_thr_we) begin
                r_thr <= i_thr_data;
            end
            if (o_q_pop) begin
                r_rd_vld <= r_row_vld[i_q_item.row];
            end
            if (r_state == S_FIN && adjust) begin
                r_row_vld[r_item.row] <= 1'b1;
            end
            if (r_state == S_FIN && r_item.train) begin
                r_hist <= {r_hist[pbp_pkg::HIST_LEN-2:0], r_item.taken};
            end
        end
    end

    assign o_valid            = r_valid;
    assign o_predicted_taken  = r_pred;
    assign o_weighted_sum     = r_sum_out;
    assign o_weights_adjusted = r_adj;

    `PBP_ASSERT(a_single_strobe, o_valid |=> !o_valid)
    `PBP_ASSERT(a_pop_only_idle, o_q_pop |-> (r_state == S_IDLE) && i_q_valid)
    `PBP_ASSERT(a_hist_on_train,
        !$stable(r_hist) |-> $past(r_state == S_FIN && r_item.train))

endmodule

### rtl/core/perceptron_branch_predictor.sv
// ----------------------------------------------------------------------------
// perceptron_branch_predictor
// perceptron predictor with a request queue in front of a serial back end
// ----------------------------------------------------------------------------
// usage:
//   a request (i_command, i_pc, i_outcome_taken) is taken when start is high
//   and busy is low. command predict only reads; command train also updates
//   the global history and, if adjusting, the row picked by the low pc bits.
//   each request yields one result, shown for one cycle with o_valid high;
//   the receiver cannot stall, so results are never held back.
//   the back end takes one request at a time from the queue and steps it
//   through row read from the weight memory, first adder-tree level and
//   final add with row write back on adjust; o_valid rises from a register
//   set in the final add. it takes no new request until the last one is
//   through; a two-entry queue lets start be issued back to back until busy rises.
//   the threshold register is written through i_cfg_valid/i_cfg_data,
//   o_cfg_ready is always high; write it only while the block is idle.
//   reset clears the queue, history, threshold (to 50) and the row valid
//   bits, so all weights read as zero right after reset.
// ----------------------------------------------------------------------------
module perceptron_branch_predictor (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_command,
    input  logic [31:0]                        i_pc,
    input  logic                               i_outcome_taken,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pbp_pkg::THR_W-1:0]          i_cfg_data,
    output logic                               o_valid,
    output logic                               o_predicted_taken,
    output logic signed [pbp_pkg::OUT_W-1:0]   o_weighted_sum,
    output logic                               o_weights_adjusted
);

    logic           q_valid, q_pop;
    pbp_pkg::t_item q_item;

    assign o_cfg_ready = 1'b1;

    // request front end
    pbp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_pc            (i_pc),
        .i_outcome_taken (i_outcome_taken),
        .o_q_valid       (q_valid),
        .o_q_item        (q_item),
        .i_q_pop         (q_pop)
    );

    // weight store and training back end
    pbp_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .i_q_item           (q_item),
        .o_q_pop            (q_pop),
        .i_thr_we           (i_cfg_valid && o_cfg_ready),
        .i_thr_data         (i_cfg_data),
        .o_valid            (o_valid),
        .o_predicted_taken  (o_predicted_taken),
        .o_weighted_sum     (o_weighted_sum),
        .o_weights_adjusted (o_weights_adjusted)
    );

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks the perceptron predictor against a behavioral copy of its weight
// rows, global history and training threshold; predict and train requests
// are driven with random pacing and every result is checked in order
// ----------------------------------------------------------------------------

// keeps the predicted state and the queue of results still to come
class pbp_outcome_book;
    int                   weight_mem [pbp_pkg::ROW_COUNT][pbp_pkg::ROW_LEN];
    logic [pbp_pkg::HIST_LEN-1:0] history;
    int                   threshold;
    logic                 due_taken [$];
    logic [12:0]          due_sum [$];
    logic                 due_adjusted [$];
    int                   mismatch_count;

    function void clear_state();
        foreach (weight_mem[r, k]) weight_mem[r][k] = 0;
        history = '0;
        threshold = pbp_pkg::THR_RESET;
        mismatch_count = 0;
    endfunction

    function int row_total(int r);
        int s;
        s = weight_mem[r][0];
        for (int i = 0; i < pbp_pkg::HIST_LEN; i++)
            s += history[i] ? weight_mem[r][i+1] : -weight_mem[r][i+1];
        return s;
    endfunction

    function int nudge(int w, bit up);
        if (up && w < 127) return w + 1;
        if (!up && w > -128) return w - 1;
        return w;
    endfunction

    // note one accepted request and queue its expected result
    function void note_request(bit is_train, logic [31:0] pc, bit taken);
        int r, s, mag, shown;
        bit pred, adj;
        r = pc % pbp_pkg::ROW_COUNT;
        s = row_total(r);
        pred = (s >= 0);
        adj = 0;
        if (is_train) begin
            mag = (s < 0) ? -s : s;
            if (pred != taken || mag < threshold) begin
                adj = 1;
                weight_mem[r][0] = nudge(weight_mem[r][0], taken);
                for (int i = 0; i < pbp_pkg::HIST_LEN; i++)
                    weight_mem[r][i+1] = nudge(weight_mem[r][i+1], history[i] == taken);
            end
            history = {history[pbp_pkg::HIST_LEN-2:0], taken};
        end
        shown = (s > 4095) ? 4095 : (s < -4096) ? -4096 : s;
        due_taken.push_back(pred);
        due_sum.push_back(shown[12:0]);
        due_adjusted.push_back(adj);
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        mismatch_count++;
    endtask

    // compare one result with the oldest expectation
    task check_result(logic taken, logic [12:0] sum, logic adjusted);
        if (due_taken.size() == 0) begin
            report("result with no request outstanding");
            return;
        end
        if (taken !== due_taken[0])
            report($sformatf("predicted_taken got %0b want %0b", taken, due_taken[0]));
        if (sum !== due_sum[0])
            report($sformatf("weighted_sum got %0d want %0d",
                $signed(sum), $signed(due_sum[0])));
        if (adjusted !== due_adjusted[0])
            report($sformatf("weights_adjusted got %0b want %0b",
                adjusted, due_adjusted[0]));
        void'(due_taken.pop_front());
        void'(due_sum.pop_front());
        void'(due_adjusted.pop_front());
    endtask
endclass

module tb_top;

    logic                             i_clk = 0;
    logic                             i_rst_n = 0;
    logic                             start = 0;
    logic                             busy;
    logic                             i_command = 0;
    logic [31:0]                      i_pc = 0;
    logic                             i_outcome_taken = 0;
    logic                             i_cfg_valid = 0;
    logic                             o_cfg_ready;
    logic [pbp_pkg::THR_W-1:0]        i_cfg_data = 0;
    logic                             o_valid;
    logic                             o_predicted_taken;
    logic signed [pbp_pkg::OUT_W-1:0] o_weighted_sum;
    logic                             o_weights_adjusted;

    pbp_outcome_book book;
    int                       idle_pct;

    perceptron_branch_predictor u_top (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    // result side: sample at the edge that ends the strobe cycle
    always @(posedge i_clk)
        if (i_rst_n && o_valid)
            book.check_result(o_predicted_taken, o_weighted_sum, o_weights_adjusted);

    // send one request, with a random gap first
    task automatic send_request(bit is_train, logic [31:0] pc, bit taken);
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(posedge i_clk);
        end
        start <= 1;
        i_command <= is_train;
        i_pc <= pc;
        i_outcome_taken <= taken;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        book.note_request(is_train, pc, taken);
    endtask

    task automatic drain();
        start <= 0;
        @(posedge i_clk);
        while (book.due_taken.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [pbp_pkg::THR_W-1:0] value);
        drain();
        i_cfg_valid <= 1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        book.threshold = value;
    endtask

    // a well-formed loop pattern on a few rows, with random noise mixed in
    task automatic random_phase(int count);
        logic [31:0] pc;
        for (int n = 0; n < count; n++) begin
            pc = $urandom();
            if ($urandom_range(3) != 0) pc = {pc[31:8], 5'd0, pc[2:0]};
            if (n == count / 2) drain();
            send_request($urandom_range(3) != 0, pc,
                $urandom_range(1) ? (pc[0] ^ book.history[2]) : 1'($urandom_range(1)));
        end
    endtask

    initial begin
        book = new();
        book.clear_state();
        idle_pct = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // extremes of pc, both commands, a taken predict that is ignored
        send_request(1'(pbp_pkg::CMD_PREDICT), 32'h0, 1);
        send_request(1'(pbp_pkg::CMD_PREDICT), 32'hFFFF_FFFF, 0);
        send_request(1'(pbp_pkg::CMD_TRAIN), 32'hFFFF_FFFF, 1);
        send_request(1'(pbp_pkg::CMD_TRAIN), 32'h0, 0);
        send_request(1'(pbp_pkg::CMD_PREDICT), 32'hFFFF_FF00, 1);
        // train one row's weights one way over and over
        for (int n = 0; n < 20; n++)
            send_request(1'(pbp_pkg::CMD_TRAIN), 32'hA5A5_5A07, 1);

        write_threshold(12'hFFF);
        idle_pct = 7;
        random_phase(300);
        for (int n = 0; n < 300; n++)
            send_request(1'(pbp_pkg::CMD_TRAIN), 32'h0000_0033, 1);
        write_threshold(12'd0);
        idle_pct = 87;
        random_phase(400);
        write_threshold(12'd50);
        idle_pct = 0;
        random_phase(500);
        write_threshold(12'd9);
        random_phase(300);
        drain();
        if (book.mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end
endmodule
